// ===== rtl/core/gcd_pkg.sv =====
// Shared types and constants for the great-circle distance unit.
package gcd_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned DIST_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_USE_MILES    = 2'd0,
    REG_RADIUS_KM    = 2'd1,
    REG_RADIUS_MILES = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  // Datapath widths
  localparam int unsigned MAG_W = 31;  // magnitude of an angle or an angle difference
  localparam int unsigned REM_W = 9;   // remainder of the divide by 360
  localparam int unsigned XW    = 34;  // rotation x and y
  localparam int unsigned ZW    = 33;  // rotation residual angle
  localparam int unsigned TW    = 32;  // Q30 sine, cosine and products
  localparam int unsigned SQW   = 64;  // root radicand and result
  localparam int unsigned VXW   = 35;  // vectoring x and y
  localparam int unsigned VZW   = 34;  // vectoring angle sum
  localparam int unsigned ROOT_STEPS = 32;

  localparam logic [9:0] DEG_TURN = 10'd360;
  localparam logic [9:0] DEG_HALF = 10'd180;
  localparam logic [31:0] QUARTER_HALF = 32'h2000_0000;

  localparam logic signed [XW-1:0]  CORDIC_K   = 34'sd652032874;
  localparam logic signed [XW-1:0]  XY_MAX     = 34'sd1073741824;
  localparam logic signed [XW-1:0]  XY_MIN     = -34'sd1073741824;
  localparam logic [30:0]           Q30_ONE    = 31'h4000_0000;
  localparam logic [63:0]           Q30_HALF   = 64'h2000_0000;
  localparam logic [SQW-1:0]        Q60_ONE    = 64'h1000_0000_0000_0000;
  localparam logic [31:0]           PI_Q30     = 32'd3373259426;
  localparam logic [DIST_W-1:0]     DIST_MAX   = 24'hFF_FFFF;
  localparam logic [CFG_DATA_W-1:0] RADIUS_KM_RST    = 24'd1630976;
  localparam logic [CFG_DATA_W-1:0] RADIUS_MILES_RST = 24'd1013504;

  // Arctangent of 2^-i in binary-angle units (2^32 per turn)
  localparam logic [31:0] ATAN_TURN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
    32'h00000000, 32'h00000000
  };

endpackage

// ===== rtl/core/great_circle_distance_unit.sv =====
// Pipelined haversine great-circle distance unit.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   in      | input     | in_valid_i / in_ready_o | lat_a_i lon_a_i lat_b_i lon_b_i
//   out     | output    | out_valid_o/out_ready_i | distance_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i cfg_data_i
//
// One point pair enters per cycle unless a stalled output has filled the pipeline.
// The stages hold the byte-a-stage divide by 360, two rotation chains and the
// 32-step root. A stalled output holds; empty stages still fill, so input stays
// open until every stage holds a transfer. Reset empties the pipeline and loads
// the radius defaults. The config port is always ready.
module great_circle_distance_unit #(
  parameter int unsigned ANGLE_FRAC_BITS = 20,
  parameter int unsigned ITER_STAGES     = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [27:0]                lat_a_i,
  input  logic signed [28:0]                lon_a_i,
  input  logic signed [27:0]                lat_b_i,
  input  logic signed [28:0]                lon_b_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [gcd_pkg::DIST_W-1:0]        distance_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gcd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [gcd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import gcd_pkg::*;

  localparam int unsigned SH_FULL = 32 - ANGLE_FRAC_BITS;
  localparam int unsigned SH_HALF = 31 - ANGLE_FRAC_BITS;
  localparam int unsigned NW      = MAG_W + SH_FULL;
  localparam int unsigned DIV_ST  = (NW + 7) / 8;
  localparam int unsigned NWP     = DIV_ST * 8;

  localparam int unsigned L_IN   = 0;
  localparam int unsigned L_RED  = DIV_ST + 1;
  localparam int unsigned L_TRIG = L_RED + ITER_STAGES + 1;
  localparam int unsigned L_MUL1 = L_TRIG + 1;
  localparam int unsigned L_MUL2 = L_TRIG + 2;
  localparam int unsigned L_HAV  = L_TRIG + 3;
  localparam int unsigned L_VEC0 = L_HAV + ROOT_STEPS + 1;
  localparam int unsigned L_ANG  = L_VEC0 + ITER_STAGES;
  localparam int unsigned L_OUT  = L_ANG + 1;
  localparam int unsigned NST    = L_OUT + 1;

  function automatic logic signed [TW-1:0] mul_q30(input logic signed [TW-1:0] a,
                                                   input logic signed [TW-1:0] b);
    logic signed [63:0] p;
    p = a * b + $signed(Q30_HALF);
    return p[61:30];
  endfunction

  // Configuration registers
  logic                  use_miles_q;
  logic [CFG_DATA_W-1:0] radius_km_q, radius_miles_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_miles_q    <= 1'b0;
      radius_km_q    <= RADIUS_KM_RST;
      radius_miles_q <= RADIUS_MILES_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_USE_MILES:    use_miles_q    <= cfg_data_i[0];
        REG_RADIUS_KM:    radius_km_q    <= cfg_data_i;
        REG_RADIUS_MILES: radius_miles_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits and per-stage advance
  logic [NST-1:0] v_q, en;

  always_comb begin
    en[NST-1] = !v_q[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[L_IN];
  assign out_valid_o = v_q[NST-1];

  // Datapath registers
  logic [REM_W-1:0]     div_rem_q [DIV_ST][4];
  logic [REM_W-1:0]     div_rem_d [DIV_ST][4];
  logic [NWP-1:0]       div_num_q [DIV_ST+1][4];
  logic [NWP-1:0]       div_num_d [DIV_ST+1][4];
  logic [3:0]           neg_q [DIV_ST+1];
  logic [3:0]           neg_d [DIV_ST+1];

  logic signed [XW-1:0] cx_q [ITER_STAGES+1][4];
  logic signed [XW-1:0] cx_d [ITER_STAGES+1][4];
  logic signed [XW-1:0] cy_q [ITER_STAGES+1][4];
  logic signed [XW-1:0] cy_d [ITER_STAGES+1][4];
  logic signed [ZW-1:0] cz_q [ITER_STAGES][4];
  logic signed [ZW-1:0] cz_d [ITER_STAGES][4];
  quad_e                cq_q [ITER_STAGES+1][4];
  quad_e                cq_d [ITER_STAGES+1][4];

  logic signed [TW-1:0] trig_q [4];
  logic signed [TW-1:0] trig_d [4];
  logic signed [TW-1:0] m_t1_q, m_c12_q, m_sl2_q, p_t1_q, p_t2_q;
  logic signed [TW-1:0] m_t1_d, m_c12_d, m_sl2_d, p_t2_d;

  logic [SQW-1:0]       sq_v_q [ROOT_STEPS][2];
  logic [SQW-1:0]       sq_v_d [ROOT_STEPS][2];
  logic [SQW-1:0]       sq_r_q [ROOT_STEPS+1][2];
  logic [SQW-1:0]       sq_r_d [ROOT_STEPS+1][2];

  logic signed [VXW-1:0] vx_q [ITER_STAGES-1];
  logic signed [VXW-1:0] vx_d [ITER_STAGES-1];
  logic signed [VXW-1:0] vy_q [ITER_STAGES-1];
  logic signed [VXW-1:0] vy_d [ITER_STAGES-1];
  logic signed [VZW-1:0] vz_q [ITER_STAGES];
  logic signed [VZW-1:0] vz_d [ITER_STAGES];

  logic [31:0]          ang_q, ang_d;
  logic [DIST_W-1:0]    dist_q, dist_d;

  // Angle to binary angle: round(|x| * 2^sh / 360), a byte of quotient a stage
  always_comb begin
    logic signed [MAG_W-1:0] a_in [4];
    logic [MAG_W-1:0]        mag;
    logic [REM_W:0]          t;
    logic [REM_W-1:0]        rem;
    logic [NWP-1:0]          num;
    a_in[0] = MAG_W'(lat_a_i);
    a_in[1] = MAG_W'(lat_b_i);
    a_in[2] = MAG_W'(lat_b_i) - MAG_W'(lat_a_i);
    a_in[3] = MAG_W'(lon_b_i) - MAG_W'(lon_a_i);
    for (int l = 0; l < 4; l++) begin
      mag = a_in[l][MAG_W-1] ? MAG_W'(-a_in[l]) : MAG_W'(a_in[l]);
      neg_d[0][l] = a_in[l][MAG_W-1];
      div_rem_d[0][l] = '0;
      div_num_d[0][l] = (NWP'(mag) << ((l < 2) ? SH_FULL : SH_HALF)) + NWP'(DEG_HALF);
    end
    for (int k = 1; k <= DIV_ST; k++) begin
      neg_d[k] = neg_q[k-1];
      for (int l = 0; l < 4; l++) begin
        rem = div_rem_q[k-1][l];
        num = div_num_q[k-1][l];
        for (int b = 0; b < 8; b++) begin
          t   = {rem, num[NWP-1]};
          num = {num[NWP-2:0], 1'b0};
          if (t >= DEG_TURN) begin
            rem    = REM_W'(t - DEG_TURN);
            num[0] = 1'b1;
          end else begin
            rem = t[REM_W-1:0];
          end
        end
        if (k < DIV_ST) div_rem_d[k][l] = rem;
        div_num_d[k][l] = num;
      end
    end
  end

  // Quadrant reduction and rotation chain
  always_comb begin
    logic [31:0]          a, ah, r;
    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] at, zn;
    for (int l = 0; l < 4; l++) begin
      a  = neg_q[DIV_ST][l] ? 32'd0 - div_num_q[DIV_ST][l][31:0]
                            : div_num_q[DIV_ST][l][31:0];
      ah = a + QUARTER_HALF;
      r  = a - {ah[31:30], 30'd0};
      cx_d[0][l] = CORDIC_K;
      cy_d[0][l] = '0;
      cz_d[0][l] = ZW'($signed(r));
      cq_d[0][l] = quad_e'(ah[31:30]);
    end
    for (int i = 1; i <= ITER_STAGES; i++) begin
      for (int l = 0; l < 4; l++) begin
        dx = cy_q[i-1][l] >>> (i - 1);
        dy = cx_q[i-1][l] >>> (i - 1);
        at = $signed({1'b0, ATAN_TURN[i-1]});
        if (cz_q[i-1][l] >= 0) begin
          cx_d[i][l] = cx_q[i-1][l] - dx;
          cy_d[i][l] = cy_q[i-1][l] + dy;
          zn = cz_q[i-1][l] - at;
        end else begin
          cx_d[i][l] = cx_q[i-1][l] + dx;
          cy_d[i][l] = cy_q[i-1][l] - dy;
          zn = cz_q[i-1][l] + at;
        end
        if (i < ITER_STAGES) cz_d[i][l] = zn;
        cq_d[i][l] = cq_q[i-1][l];
      end
    end
  end

  // Clamp, unfold the quadrant: cosine for the latitudes, sine for the half differences
  always_comb begin
    logic signed [XW-1:0] x, y, co, si;
    for (int l = 0; l < 4; l++) begin
      x = cx_q[ITER_STAGES][l];
      y = cy_q[ITER_STAGES][l];
      if (x > XY_MAX) x = XY_MAX;
      else if (x < XY_MIN) x = XY_MIN;
      if (y > XY_MAX) y = XY_MAX;
      else if (y < XY_MIN) y = XY_MIN;
      case (cq_q[ITER_STAGES][l])
        QUAD_0:  begin co = x;  si = y;  end
        QUAD_1:  begin co = -y; si = x;  end
        QUAD_2:  begin co = -x; si = -y; end
        QUAD_3:  begin co = y;  si = -x; end
        default: begin co = x;  si = y;  end
      endcase
      trig_d[l] = (l < 2) ? TW'(co) : TW'(si);
    end
  end

  // Products, haversine sum and the two roots
  assign m_t1_d  = mul_q30(trig_q[2], trig_q[2]);
  assign m_c12_d = mul_q30(trig_q[0], trig_q[1]);
  assign m_sl2_d = mul_q30(trig_q[3], trig_q[3]);
  assign p_t2_d  = mul_q30(m_c12_q, m_sl2_q);

  always_comb begin
    logic signed [TW:0] s;
    logic [30:0]        h;
    logic [SQW-1:0]     bit_w, tr;
    s = (TW+1)'(p_t1_q) + (TW+1)'(p_t2_q);
    if (s < 0) h = '0;
    else if (s > $signed({2'b00, Q30_ONE})) h = Q30_ONE;
    else h = s[30:0];
    sq_v_d[0][0] = SQW'(h) << 30;
    sq_v_d[0][1] = SQW'(Q30_ONE - h) << 30;
    sq_r_d[0][0] = '0;
    sq_r_d[0][1] = '0;
    for (int i = 0; i < ROOT_STEPS; i++) begin
      bit_w = SQW'(1) << (62 - 2 * i);
      for (int l = 0; l < 2; l++) begin
        tr = sq_r_q[i][l] + bit_w;
        if (sq_v_q[i][l] >= tr) begin
          if (i < ROOT_STEPS - 1) sq_v_d[i+1][l] = sq_v_q[i][l] - tr;
          sq_r_d[i+1][l] = (sq_r_q[i][l] >> 1) + bit_w;
        end else begin
          if (i < ROOT_STEPS - 1) sq_v_d[i+1][l] = sq_v_q[i][l];
          sq_r_d[i+1][l] = sq_r_q[i][l] >> 1;
        end
      end
    end
  end

  // Vectoring chain: atan2(sqrt(h), sqrt(1-h))
  always_comb begin
    logic signed [VXW-1:0] x, y, dx, dy;
    logic signed [VZW-1:0] z, at;
    for (int j = 0; j < ITER_STAGES; j++) begin
      if (j == 0) begin
        x = $signed({4'd0, sq_r_q[ROOT_STEPS][1][30:0]});
        y = $signed({4'd0, sq_r_q[ROOT_STEPS][0][30:0]});
        z = '0;
      end else begin
        x = vx_q[j-1];
        y = vy_q[j-1];
        z = vz_q[j-1];
      end
      dx = y >>> j;
      dy = x >>> j;
      at = $signed({2'b00, ATAN_TURN[j]});
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + at;
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - at;
      end
      if (j < ITER_STAGES - 1) begin
        vx_d[j] = x;
        vy_d[j] = y;
      end
      vz_d[j] = z;
    end
  end

  // Angle to radians, then scale by the diameter
  always_comb begin
    logic [30:0] zc;
    logic [63:0] pa;
    if (vz_q[ITER_STAGES-1] < 0) zc = '0;
    else if (vz_q[ITER_STAGES-1] > $signed({3'b000, Q30_ONE})) zc = Q30_ONE;
    else zc = vz_q[ITER_STAGES-1][30:0];
    pa    = 64'(zc) * 64'(PI_Q30) + Q30_HALF;
    ang_d = pa[61:30];
  end

  always_comb begin
    logic [CFG_DATA_W-1:0] rad;
    logic [55:0]           pr;
    logic [57:0]           sd;
    rad = use_miles_q ? radius_miles_q : radius_km_q;
    pr  = 56'(rad) * 56'(ang_q);
    sd  = {1'b0, pr, 1'b0} + 58'(Q30_HALF);
    dist_d = (sd[57:30] > 28'(DIST_MAX)) ? DIST_MAX : sd[53:30];
  end

  assign distance_o = dist_q;

  // Payload registers advance with their stage
  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= DIV_ST; k++) begin
      if (en[L_IN+k]) begin
        neg_q[k]     <= neg_d[k];
        div_num_q[k] <= div_num_d[k];
        if (k < DIV_ST) div_rem_q[k] <= div_rem_d[k];
      end
    end
    for (int i = 0; i <= ITER_STAGES; i++) begin
      if (en[L_RED+i]) begin
        cx_q[i] <= cx_d[i];
        cy_q[i] <= cy_d[i];
        cq_q[i] <= cq_d[i];
        if (i < ITER_STAGES) cz_q[i] <= cz_d[i];
      end
    end
    if (en[L_TRIG]) trig_q <= trig_d;
    if (en[L_MUL1]) begin
      m_t1_q  <= m_t1_d;
      m_c12_q <= m_c12_d;
      m_sl2_q <= m_sl2_d;
    end
    if (en[L_MUL2]) begin
      p_t1_q <= m_t1_q;
      p_t2_q <= p_t2_d;
    end
    for (int i = 0; i <= ROOT_STEPS; i++) begin
      if (en[L_HAV+i]) begin
        sq_r_q[i] <= sq_r_d[i];
        if (i < ROOT_STEPS) sq_v_q[i] <= sq_v_d[i];
      end
    end
    for (int j = 0; j < ITER_STAGES; j++) begin
      if (en[L_VEC0+j]) begin
        vz_q[j] <= vz_d[j];
        if (j < ITER_STAGES - 1) begin
          vx_q[j] <= vx_d[j];
          vy_q[j] <= vy_d[j];
        end
      end
    end
    if (en[L_ANG]) ang_q  <= ang_d;
    if (en[L_OUT]) dist_q <= dist_d;
  end

  // Input backpressure only comes from a full pipe behind a stalled output
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while the output side is free");

  // Registers change only on a config transfer
  a_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_valid_i |=> ($stable(use_miles_q) && $stable(radius_km_q)
                      && $stable(radius_miles_q)))
    else $error("config register changed without a transfer");

  // The two root radicands always add up to one in Q60
  a_hav_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[L_HAV] |-> ((sq_v_q[0][0] + sq_v_q[0][1]) == Q60_ONE))
    else $error("haversine radicands do not sum to one");

endmodule

// ===== tb/great_circle_distance_unit_checker.sv =====
// Checker for the great-circle distance unit: predicts each distance and compares it.
`timescale 1ns / 1ps
module great_circle_distance_unit_checker
  import gcd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic signed [27:0]      lat_a_i,
  input  logic signed [28:0]      lon_a_i,
  input  logic signed [27:0]      lat_b_i,
  input  logic signed [28:0]      lon_b_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [DIST_W-1:0]       distance_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output int                      checked_o
);

  localparam int FRAC_BITS = 20;
  localparam int STAGES    = 24;
  localparam longint ONE_Q30  = 64'sd1073741824;
  localparam longint HALF_Q30 = 64'sd536870912;
  localparam longint unsigned TURN_MASK = 64'hFFFF_FFFF;

  logic                  miles_sel;
  logic [CFG_DATA_W-1:0] km_radius;
  logic [CFG_DATA_W-1:0] mile_radius;
  logic [DIST_W-1:0]     expected_dist_q[$];

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // degrees scaled by 2^FRAC_BITS to a binary angle, scaled up by 2^sh
  function automatic longint unsigned deg_to_turn(longint deg, int sh);
    longint unsigned den, mag, q;
    den = 64'd360 << FRAC_BITS;
    mag = deg < 0 ? longint'(-deg) : longint'(deg);
    q = ((mag << sh) + (den >> 1)) / den;
    if (deg < 0) q = 64'd0 - q;
    return q & TURN_MASK;
  endfunction

  task automatic rotate_sincos(input longint unsigned ang, output longint co,
                               output longint si);
    longint unsigned quad, resid;
    longint x, y, z, dx, dy;
    quad  = ((ang + 64'h2000_0000) & TURN_MASK) >> 30;
    resid = (ang - (quad << 30)) & TURN_MASK;
    z = resid >= 64'h8000_0000 ? longint'(resid) - 64'sd4294967296 : longint'(resid);
    x = longint'(CORDIC_K);
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TURN[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TURN[i]);
      end
    end
    x = clip(x, -ONE_Q30, ONE_Q30);
    y = clip(y, -ONE_Q30, ONE_Q30);
    case (quad_e'(quad[1:0]))
      QUAD_0: begin co = x;  si = y;  end
      QUAD_1: begin co = -y; si = x;  end
      QUAD_2: begin co = -x; si = -y; end
      default: begin co = y; si = -x; end
    endcase
  endtask

  function automatic longint q30_mul(longint a, longint b);
    return (a * b + HALF_Q30) >>> 30;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  task automatic predict_distance(input longint la, oa, lb, ob,
                                  output logic [DIST_W-1:0] dist_val);
    longint c1, s1, c2, s2, cp, sp, cl, sl, hav, x, y, z, dx, dy;
    longint unsigned ang, rad, d;
    rotate_sincos(deg_to_turn(la, 32), c1, s1);
    rotate_sincos(deg_to_turn(lb, 32), c2, s2);
    rotate_sincos(deg_to_turn(lb - la, 31), cp, sp);
    rotate_sincos(deg_to_turn(ob - oa, 31), cl, sl);
    hav = clip(q30_mul(sp, sp) + q30_mul(q30_mul(c1, c2), q30_mul(sl, sl)), 0, ONE_Q30);
    y = longint'(floor_root(longint'(hav) << 30));
    x = longint'(floor_root(longint'(ONE_Q30 - hav) << 30));
    z = 0;
    // vector (x, y) onto the x axis; z collects the angle
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(ATAN_TURN[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_TURN[i]);
      end
    end
    z = clip(z, 0, ONE_Q30);
    ang = (longint'(z) * 64'd3373259426 + 64'd536870912) >> 30;
    rad = miles_sel ? mile_radius : km_radius;
    d = (64'd2 * rad * ang + 64'd536870912) >> 30;
    dist_val = d > 64'hFF_FFFF ? DIST_MAX : d[DIST_W-1:0];
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [DIST_W-1:0] exp_dist;
    if (!rst_ni) begin
      miles_sel   <= 1'b0;
      km_radius   <= RADIUS_KM_RST;
      mile_radius <= RADIUS_MILES_RST;
      expected_dist_q.delete();
      fail_count_o = 0;
      checked_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_USE_MILES:    miles_sel   <= cfg_data_i[0];
          REG_RADIUS_KM:    km_radius   <= cfg_data_i;
          REG_RADIUS_MILES: mile_radius <= cfg_data_i;
          default: ;  // drop writes to unmapped indexes
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        predict_distance(longint'(lat_a_i), longint'(lon_a_i), longint'(lat_b_i),
                         longint'(lon_b_i), exp_dist);
        expected_dist_q.push_back(exp_dist);
      end
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (expected_dist_q.size() == 0) begin
          report_mismatch($sformatf("unexpected distance %0d", distance_i));
        end else begin
          exp_dist = expected_dist_q.pop_front();
          if (distance_i !== exp_dist)
            report_mismatch($sformatf("distance %0d, expected %0d", distance_i, exp_dist));
        end
      end
      pending_o = expected_dist_q.size();
    end
  end

endmodule

// ===== tb/great_circle_distance_unit_test.sv =====
// Testbench top for the great-circle distance unit: stimulus, idling and verdict.
`timescale 1ns / 1ps
module great_circle_distance_unit_test;
  import gcd_pkg::*;

  localparam int LAT_MAX = 94371840;
  localparam int LON_MAX = 188743680;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 120;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [27:0] lat_a_i = '0;
  logic signed [28:0] lon_a_i = '0;
  logic signed [27:0] lat_b_i = '0;
  logic signed [28:0] lon_b_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [DIST_W-1:0] distance_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int fail_count, pending, checked;
  int sent_pairs, cfg_writes;
  int rx_hold_cycles = 0;
  int rx_stall_pct = 20;
  int idle_cycles = 0;

  great_circle_distance_unit i_dut (.*);

  great_circle_distance_unit_checker i_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o),
    .lat_a_i, .lon_a_i, .lat_b_i, .lon_b_i,
    .out_valid_i(out_valid_o), .out_ready_i, .distance_i(distance_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stalls, mostly short, plus a forced long hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        rx_hold_cycles--;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < rx_stall_pct) begin
        out_ready_i <= 1'b0;
        stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(0, 3);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d distances pending",
               IDLE_LIMIT, pending);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_pair(input int la, input int oa, input int lb, input int ob);
    logic taken;
    in_valid_i <= 1'b1;
    lat_a_i <= 28'(la);
    lon_a_i <= 29'(oa);
    lat_b_i <= 28'(lb);
    lon_b_i <= 29'(ob);
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    sent_pairs++;
  endtask

  task automatic idle_input(input int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // sample the pending count away from the clock edge
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    logic taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    cfg_writes++;
  endtask

  function automatic int rand_lat();
    return int'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
  endfunction

  function automatic int rand_lon();
    return int'($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
  endfunction

  task automatic random_pairs(input int count, input int gap_pct);
    int sel, la, oa, lb, ob;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      la = rand_lat();
      oa = rand_lon();
      if (sel < 60) begin
        lb = rand_lat();
        ob = rand_lon();
      end else if (sel < 85) begin
        // nearby points: small differences exercise the low end of the root
        lb = la + int'($urandom_range(0, 1 << 18)) - (1 << 17);
        ob = oa + int'($urandom_range(0, 1 << 18)) - (1 << 17);
      end else begin
        // raw bit patterns, including out-of-range angles
        la = $signed(28'($urandom));
        oa = $signed(29'($urandom));
        lb = $signed(28'($urandom));
        ob = $signed(29'($urandom));
      end
      send_pair(la, oa, lb, ob);
      if ($urandom_range(0, 99) < gap_pct)
        idle_input(($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 3));
      if ($urandom_range(0, 199) == 0) wait_drained();
    end
  endtask

  initial begin
    sent_pairs = 0;
    cfg_writes = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: identical points, antipodes, poles, range and bit extremes
    send_pair(0, 0, 0, 0);
    send_pair(LAT_MAX / 2, LON_MAX / 3, LAT_MAX / 2, LON_MAX / 3);
    send_pair(0, 0, 0, LON_MAX);
    send_pair(0, -LON_MAX, 0, LON_MAX);
    send_pair(LAT_MAX, 0, -LAT_MAX, 0);
    send_pair(-LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
    send_pair(LAT_MAX, 0, LAT_MAX, LON_MAX);
    send_pair(28'sh7FF_FFFF, 29'shFFF_FFFF, -28'sh800_0000, -29'sh1000_0000);
    send_pair(-28'sh800_0000, -29'sh1000_0000, 28'sh7FF_FFFF, 29'shFFF_FFFF);
    send_pair(-28'sh800_0000, 29'shFFF_FFFF, -28'sh800_0000, -29'sh1000_0000);
    send_pair(1, 1, -1, -1);
    send_pair(0, 0, 1, 0);
    send_pair(0, 0, 0, 1);
    send_pair(LAT_MAX / 4, 0, LAT_MAX / 4 + 1, 1);
    send_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
    send_pair(-LAT_MAX, -LON_MAX, -LAT_MAX, LON_MAX);
    wait_drained();

    // zero radius and full radius (saturates) for both units
    cfg_write(REG_RADIUS_KM, '0);
    send_pair(0, 0, 0, LON_MAX);
    send_pair(LAT_MAX, 0, 0, 0);
    wait_drained();
    cfg_write(REG_RADIUS_KM, DIST_MAX);
    cfg_write(REG_UNMAPPED, 24'h00_1234);
    send_pair(0, 0, 0, LON_MAX);
    send_pair(0, 0, 0, LON_MAX / 1000);
    wait_drained();
    cfg_write(REG_USE_MILES, 24'd1);
    cfg_write(REG_RADIUS_MILES, '0);
    send_pair(0, 0, 0, LON_MAX);
    wait_drained();
    cfg_write(REG_RADIUS_MILES, DIST_MAX);
    send_pair(LAT_MAX, 0, -LAT_MAX, 0);
    wait_drained();

    // random phases across radius settings
    cfg_write(REG_USE_MILES, '0);
    cfg_write(REG_RADIUS_KM, RADIUS_KM_RST);
    random_pairs(280, 30);
    wait_drained();

    cfg_write(REG_USE_MILES, 24'hFF_FFFF);
    cfg_write(REG_RADIUS_MILES, RADIUS_MILES_RST);
    rx_stall_pct = 0;
    random_pairs(240, 0);
    wait_drained();

    // long receiver hold-off while the sender keeps pushing
    rx_stall_pct = 20;
    rx_hold_cycles = 300;
    random_pairs(200, 0);
    wait_drained();

    cfg_write(REG_RADIUS_MILES, 24'($urandom_range(0, 24'hFF_FFFF)));
    rx_stall_pct = 50;
    random_pairs(280, 40);
    wait_drained();

    cfg_write(REG_USE_MILES, '0);
    cfg_write(REG_RADIUS_KM, 24'($urandom_range(0, 24'hFF_FFFF)));
    rx_stall_pct = 10;
    random_pairs(280, 10);
    wait_drained();

    cfg_write(REG_RADIUS_KM, 24'd1);
    rx_stall_pct = 25;
    random_pairs(280, 25);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d point pairs, %0d distances checked, %0d register writes",
             sent_pairs, checked, cfg_writes);
    $display("settings: both units, zero, unit and full radius, hold-off and drain pauses");
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
